// ===== hdl/hse_pkg.sv =====
`timescale 1ns / 1ps

package hse_pkg;

    localparam int SIZE   = 64;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 7;
    localparam int ADDR_W = $clog2(SIZE);
    localparam int CNT_W  = $clog2(SIZE + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CFG_W-1:0]         t_cfg;

    // one write port, two registered read ports
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_mem_req;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_BUILD   = 9'b000000010,
        S_LDV     = 9'b000000100,
        S_SIFT_RD = 9'b000001000,
        S_KIDS    = 9'b000010000,
        S_NODE    = 9'b000100000,
        S_EXTRACT = 9'b001000000,
        S_SWAP    = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

endpackage

// ===== hdl/hse_heap_mem.sv =====
`timescale 1ns / 1ps

module hse_heap_mem (
    input  logic             i_clk,
    input  hse_pkg::t_mem_req i_req,
    output hse_pkg::t_data   o_rdata_a,
    output hse_pkg::t_data   o_rdata_b
);
    import hse_pkg::*;

    t_data r_mem [SIZE];
    t_data r_rdata_a;
    t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/hse_cmp.sv =====
`timescale 1ns / 1ps

module hse_cmp (
    input  hse_pkg::t_data i_a,
    input  hse_pkg::t_data i_b,
    output logic           o_gt
);
    import hse_pkg::*;

    // signed (two's complement) compare, a > b
    assign o_gt = (i_a > i_b);

endmodule

// ===== hdl/hse_ctrl.sv =====
`timescale 1ns / 1ps

module hse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hse_pkg::t_data    i_value,
    input  logic              i_cfg_we,
    input  hse_pkg::t_cfg     i_cfg_item_count,
    input  hse_pkg::t_data    i_rdata_a,
    input  hse_pkg::t_data    i_rdata_b,
    input  logic              i_gt,
    output hse_pkg::t_mem_req o_req,
    output hse_pkg::t_data    o_cmp_a,
    output hse_pkg::t_data    o_cmp_b,
    output logic              o_busy,
    output logic              o_strobe,
    output hse_pkg::t_data    o_value,
    output logic              o_last
);
    import hse_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_load,  n_load;
    t_cfg   r_item,  n_item;
    t_cnt   r_i,     n_i;
    t_addr  r_node,  n_node;
    t_cnt   r_len,   n_len;
    t_data  r_v,     n_v;
    t_data  r_big,   n_big;
    t_addr  r_big_idx, n_big_idx;
    logic   r_extract, n_extract;
    t_cnt   r_k,     n_k;
    logic   r_emit_vld, n_emit_vld;
    logic   r_emit_last, n_emit_last;
    logic   r_strobe;
    logic   r_last;
    t_data  r_out;

    t_cnt   eff_n;
    t_cnt   child;
    t_cnt   child_r;

    // count 0 acts as 1, above SIZE acts as SIZE
    always_comb begin
        if (r_item == '0) begin
            eff_n = CNT_W'(1);
        end else if (CNT_W'(r_item) > CNT_W'(SIZE)) begin
            eff_n = CNT_W'(SIZE);
        end else begin
            eff_n = CNT_W'(r_item);
        end
    end

    assign child   = {r_node, 1'b1};
    assign child_r = {r_node, 1'b0} + CNT_W'(2);

    always_comb begin
        n_state     = r_state;
        n_load      = r_load;
        n_item      = r_item;
        n_i         = r_i;
        n_node      = r_node;
        n_len       = r_len;
        n_v         = r_v;
        n_big       = r_big;
        n_big_idx   = r_big_idx;
        n_extract   = r_extract;
        n_k         = r_k;
        n_emit_vld  = 1'b0;
        n_emit_last = 1'b0;
        o_req       = '0;
        o_cmp_a     = r_big;
        o_cmp_b     = r_v;

        if (i_cfg_we) begin
            n_item = i_cfg_item_count;
            n_load = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_load[ADDR_W-1:0];
                    o_req.wdata = i_value;
                    if (r_load + CNT_W'(1) >= eff_n) begin
                        n_load = '0;
                        if (eff_n > CNT_W'(1)) begin
                            n_i       = eff_n >> 1;
                            n_extract = 1'b0;
                            n_state   = S_BUILD;
                        end else begin
                            n_k     = '0;
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_load = r_load + CNT_W'(1);
                    end
                end
            end
            S_BUILD: begin
                if (r_i == '0) begin
                    n_i     = eff_n;
                    n_state = S_EXTRACT;
                end else begin
                    n_node        = r_i[ADDR_W-1:0] - ADDR_W'(1);
                    n_len         = eff_n;
                    o_req.raddr_a = r_i[ADDR_W-1:0] - ADDR_W'(1);
                    n_i           = r_i - CNT_W'(1);
                    n_state       = S_LDV;
                end
            end
            S_LDV: begin
                n_v     = i_rdata_a;
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                if (child < r_len) begin
                    o_req.raddr_a = child[ADDR_W-1:0];
                    o_req.raddr_b = child_r[ADDR_W-1:0];
                    n_state       = S_KIDS;
                end else begin
                    // leaf reached: drop the carried value into the hole
                    o_req.we    = 1'b1;
                    o_req.waddr = r_node;
                    o_req.wdata = r_v;
                    n_state     = r_extract ? S_EXTRACT : S_BUILD;
                end
            end
            S_KIDS: begin
                o_cmp_a = i_rdata_b;
                o_cmp_b = i_rdata_a;
                if ((child_r < r_len) && i_gt) begin
                    n_big     = i_rdata_b;
                    n_big_idx = child_r[ADDR_W-1:0];
                end else begin
                    n_big     = i_rdata_a;
                    n_big_idx = child[ADDR_W-1:0];
                end
                n_state = S_NODE;
            end
            S_NODE: begin
                o_cmp_a     = r_big;
                o_cmp_b     = r_v;
                o_req.we    = 1'b1;
                o_req.waddr = r_node;
                if (i_gt) begin
                    o_req.wdata = r_big;
                    n_node      = r_big_idx;
                    n_state     = S_SIFT_RD;
                end else begin
                    o_req.wdata = r_v;
                    n_state     = r_extract ? S_EXTRACT : S_BUILD;
                end
            end
            S_EXTRACT: begin
                if (r_i <= CNT_W'(1)) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    o_req.raddr_a = '0;
                    o_req.raddr_b = r_i[ADDR_W-1:0] - ADDR_W'(1);
                    n_state       = S_SWAP;
                end
            end
            S_SWAP: begin
                // root goes to the tail, tail value sifts from the root
                o_req.we    = 1'b1;
                o_req.waddr = r_i[ADDR_W-1:0] - ADDR_W'(1);
                o_req.wdata = i_rdata_a;
                n_v         = i_rdata_b;
                n_node      = '0;
                n_len       = r_i - CNT_W'(1);
                n_i         = r_i - CNT_W'(1);
                n_extract   = 1'b1;
                n_state     = S_SIFT_RD;
            end
            S_EMIT: begin
                o_req.raddr_a = r_k[ADDR_W-1:0];
                n_emit_vld    = 1'b1;
                n_emit_last   = (r_k + CNT_W'(1) == eff_n);
                if (r_k + CNT_W'(1) == eff_n) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load      <= '0;
            r_item      <= CFG_W'(SIZE);
            r_emit_vld  <= 1'b0;
            r_emit_last <= 1'b0;
            r_strobe    <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load      <= n_load;
            r_item      <= n_item;
            r_emit_vld  <= n_emit_vld;
            r_emit_last <= n_emit_last;
            r_strobe    <= r_emit_vld;
            r_last      <= r_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_node    <= n_node;
        r_len     <= n_len;
        r_v       <= n_v;
        r_big     <= n_big;
        r_big_idx <= n_big_idx;
        r_extract <= n_extract;
        r_k       <= n_k;
        r_out     <= i_rdata_a;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_value  = r_out;
    assign o_last   = r_last;

endmodule

// ===== hdl/heap_sort_engine.sv =====
`timescale 1ns / 1ps
// Loading: one value per cycle while busy is low; a set of n values is held until complete.
// Sort: after the n-th transfer busy stays high while the heap is built and then extracted;
// each heap level of the sift loop steps through S_SIFT_RD, S_KIDS and S_NODE.
// Results: n consecutive strobes, the first once the emit flags pass r_emit_vld and r_strobe; no stall.
// Reset: synchronous, active low; clears control, item_count returns to 64.

module heap_sort_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hse_pkg::t_data       i_value,
    input  logic                 i_cfg_we,
    input  hse_pkg::t_cfg        i_cfg_item_count,
    output logic                 o_strobe,
    output hse_pkg::t_data       o_sorted_value,
    output logic                 o_last
);
    import hse_pkg::*;

    // Shared datapath: a dual-read heap store and one signed comparator,
    // both driven by the sequencer. A sift-down carries the moving value
    // in a register and only writes the hole, so each level costs:
    //   read both children -> pick larger child -> compare against carried value.
    t_mem_req req;
    t_data    rdata_a;
    t_data    rdata_b;
    t_data    cmp_a;
    t_data    cmp_b;
    logic     gt;
    t_data    out_value;

    hse_heap_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    hse_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (gt)
    );

    hse_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_value          (i_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_item_count (i_cfg_item_count),
        .i_rdata_a        (rdata_a),
        .i_rdata_b        (rdata_b),
        .i_gt             (gt),
        .o_req            (req),
        .o_cmp_a          (cmp_a),
        .o_cmp_b          (cmp_b),
        .o_busy           (busy),
        .o_strobe         (o_strobe),
        .o_value          (out_value),
        .o_last           (o_last)
    );

    // Output register lives in the sequencer; the emit pass reads one entry a cycle.
    assign o_sorted_value = out_value;

endmodule

// ===== hdl/hse_checker.sv =====
`timescale 1ns / 1ps

module hse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic        o_last
);

    // last only marks a live result
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    // busy only rises on an accepted transfer
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // results may only trail the busy window, checked against the past values of busy
    a_strobe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !busy) |-> ($past(busy) || $past(busy, 2)))
        else $error("result outside sort window");

    // a run ends cleanly
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result straight after last");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_last   (o_last)
);
